/* hdl/pol_pkg.sv */
// Shared types for the positional ordered list: operation and status codes,
// and the control word broadcast along the cell chain. No dependencies.
package pol_pkg;

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_INSERT   = 3'd1,
    OP_REM_LAST = 3'd2,
    OP_REM_AT   = 3'd3,
    OP_READ     = 3'd4
  } pol_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } pol_status_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_INS  = 2'd1,
    ACT_REM  = 2'd2
  } pol_act_e;

  // Broadcast to every cell; positions and counts fit DEPTH up to 256.
  typedef struct packed {
    pol_act_e   kind;
    logic [8:0] pos;
    logic [8:0] cnt;
  } pol_ctrl_t;

endpackage

/* hdl/pol_cell.sv */
// One slot of the list chain: holds a word, loads the new element, or takes
// the word of its left or right neighbor. Depends on pol_pkg.
module pol_cell import pol_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int INDEX      = 0
) (
  input  logic                  clk_i,
  input  pol_ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0] element_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [9:0] Idx = 10'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [9:0]            pos_w, cnt_w;

  assign pos_w = {1'b0, ctrl_i.pos};
  assign cnt_w = {1'b0, ctrl_i.cnt};

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.kind)
      ACT_INS: begin
        if (Idx == pos_w) begin
          data_d = element_i;
        end else if (Idx > pos_w && Idx <= cnt_w) begin
          data_d = left_i;
        end
      end
      ACT_REM: begin
        // entries behind the removed one move toward the head
        if (Idx >= pos_w && (Idx + 10'd1) < cnt_w) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hdl/positional_ordered_list.sv */
// Positional ordered list: a bounded list of words held in a chain of cells.
// Input channel (in_valid_i/in_ready_o) carries operation, position and
// element; output channel (out_valid_o/out_ready_i) carries one result item
// per input item: status, read value, count, empty flag, head and tail.
// Operations: append, insert at position, remove last, remove at position,
// read at position. An insert or remove shifts all cells behind the target
// position by one place together, as the item is accepted.
// Timing: at acceptance the cells update and the state goes busy; from busy
// the result is registered from the cells into the output register, raising
// out_valid_o, as soon as that register is free. A new item is not taken
// until the previous one's result has been loaded into the output register.
// The output register parts the channels: a new item is accepted while an
// earlier result still waits. If the receiver stalls, the next result is
// held in the cells until the output register frees, and input stays closed.
// Reset clears the count and the handshake state; slot contents are not
// cleared, since only held entries are ever read.
// Depends on pol_pkg and pol_cell.
module positional_ordered_list import pol_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] element_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [4:0]  entry_total_o,
  output logic        is_empty_o,
  output logic [31:0] head_value_o,
  output logic [31:0] tail_value_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [8:0] Full = 9'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } pol_state_e;

  pol_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  pol_status_e   status_q, status_d;
  logic          is_read_q, is_read_d;
  logic [AW-1:0] rpos_q;
  logic          out_valid_q;
  logic          accept, load;

  logic [DATA_WIDTH-1:0] word_w [DEPTH];
  logic [DATA_WIDTH-1:0] elem_w;
  pol_ctrl_t             ctrl_d, ctrl_w;
  logic [8:0]            cnt9, pos9;
  logic [9:0]            pos10, cnt10;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign load       = (state_q == S_BUSY) && (!out_valid_q || out_ready_i);
  assign elem_w     = DATA_WIDTH'(element_i);

  assign cnt9  = 9'(count_q);
  assign pos9  = {1'b0, position_i};
  assign pos10 = {2'b00, position_i};
  assign cnt10 = {1'b0, cnt9};

  always_comb begin
    ctrl_d.kind = ACT_NONE;
    ctrl_d.pos  = pos9;
    ctrl_d.cnt  = cnt9;
    status_d    = ST_OK;
    is_read_d   = 1'b0;
    count_d     = count_q;
    unique case (pol_op_e'(operation_i))
      OP_APPEND, OP_INSERT: begin
        if (cnt9 == Full) begin
          status_d = ST_FULL;
        end else begin
          ctrl_d.kind = ACT_INS;
          if (pol_op_e'(operation_i) == OP_APPEND || pos9 > cnt9) begin
            ctrl_d.pos = cnt9;
          end
          count_d = count_q + CW'(1);
        end
      end
      OP_REM_LAST, OP_REM_AT: begin
        if (cnt9 == 9'd0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl_d.kind = ACT_REM;
          // head removal only with more than one entry; other edges drop the tail
          if (pol_op_e'(operation_i) == OP_REM_LAST ||
              !((pos9 == 9'd0 && cnt9 > 9'd1) ||
                (pos9 != 9'd0 && (pos10 + 10'd1) < cnt10))) begin
            ctrl_d.pos = cnt9 - 9'd1;
          end
          count_d = count_q - CW'(1);
        end
      end
      OP_READ: begin
        is_read_d = 1'b1;
        if (!(pos9 < cnt9)) begin
          status_d = ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_w      = ctrl_d;
    ctrl_w.kind = accept ? ctrl_d.kind : ACT_NONE;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = word_w[i];
    end else begin : g_mid_l
      assign left_w = word_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = word_w[i];
    end else begin : g_mid_r
      assign right_w = word_w[i+1];
    end
    pol_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl_w),
      .element_i(elem_w),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (word_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_BUSY;
      S_BUSY:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        count_q <= count_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      is_read_q <= is_read_d;
      rpos_q    <= position_i[AW-1:0];
    end
  end

  // result capture from the settled cells
  logic [63:0]   rd_w, hd_w, tl_w;
  logic [AW-1:0] tidx;
  assign tidx = AW'(count_q - CW'(1));
  assign rd_w = 64'(word_w[rpos_q]);
  assign hd_w = 64'(word_w[0]);
  assign tl_w = 64'(word_w[tidx]);

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o      <= status_q;
      read_value_o  <= (is_read_q && status_q == ST_OK) ? rd_w[31:0] : 32'd0;
      entry_total_o <= 5'(count_q);
      is_empty_o    <= (count_q == '0);
      head_value_o  <= (count_q == '0) ? 32'd0 : hd_w[31:0];
      tail_value_o  <= (count_q == '0) ? 32'd0 : tl_w[31:0];
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("count exceeds depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_BUSY))
    else $error("accepted item did not enter busy");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_BUSY))
    else $error("result without an item in flight");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) |=> $stable(count_q))
    else $error("count moved while busy");
`endif

endmodule

/* verif/pol_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the positional ordered list: watches both channels,
// keeps its own copy of the list to predict each result item, and compares.
// Depends on pol_pkg.
module pol_result_checker import pol_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  position_i,
  input  logic [31:0] element_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] read_value_i,
  input  logic [4:0]  entry_total_i,
  input  logic        is_empty_i,
  input  logic [31:0] head_value_i,
  input  logic [31:0] tail_value_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    pol_status_e status;
    logic [31:0] read_value;
    logic [4:0]  entry_total;
    logic        is_empty;
    logic [31:0] head_value;
    logic [31:0] tail_value;
  } list_result_t;

  logic [31:0]  list_words [DEPTH];
  int           held_total;
  list_result_t expected_results [$];
  list_result_t oldest;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic pol_status_e insert_word(int pos, logic [31:0] word);
    int i;
    if (held_total >= DEPTH) return ST_FULL;
    if (pos > held_total) pos = held_total;
    for (i = held_total; i > pos; i--) list_words[i] = list_words[i - 1];
    list_words[pos] = word;
    held_total++;
    return ST_OK;
  endfunction

  function automatic pol_status_e remove_word(int pos);
    int i;
    if (held_total == 0) return ST_EMPTY;
    // only the head (with company) and true middle slots are removed in place
    if (!(pos == 0 && held_total > 1) && !(pos > 0 && pos < held_total - 1))
      pos = held_total - 1;
    for (i = pos; i + 1 < held_total; i++) list_words[i] = list_words[i + 1];
    held_total--;
    return ST_OK;
  endfunction

  function automatic list_result_t predict_result(logic [2:0] op, int pos, logic [31:0] word);
    list_result_t res;
    res.status     = ST_OK;
    res.read_value = '0;
    case (op)
      OP_APPEND:   res.status = insert_word(held_total, word);
      OP_INSERT:   res.status = insert_word(pos, word);
      OP_REM_LAST: res.status = remove_word(held_total == 0 ? 0 : held_total - 1);
      OP_REM_AT:   res.status = remove_word(pos);
      OP_READ: begin
        if (pos < held_total) res.read_value = list_words[pos];
        else res.status = ST_RANGE;
      end
      default: ;  // unused codes leave the list alone
    endcase
    res.entry_total = 5'(held_total);
    res.is_empty    = (held_total == 0);
    res.head_value  = (held_total == 0) ? '0 : list_words[0];
    res.tail_value  = (held_total == 0) ? '0 : list_words[held_total - 1];
    return res;
  endfunction

  // Sampled at the edge: all stimulus changes by nonblocking assignment.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      held_total   = 0;
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      // pop before push: a result never belongs to an item taken at the same edge
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {30'b0, status_i}, '0);
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", {30'b0, status_i}, {30'b0, oldest.status});
          check_field("read_value", read_value_i, oldest.read_value);
          check_field("entry_total", {27'b0, entry_total_i}, {27'b0, oldest.entry_total});
          check_field("is_empty", {31'b0, is_empty_i}, {31'b0, oldest.is_empty});
          check_field("head_value", head_value_i, oldest.head_value);
          check_field("tail_value", tail_value_i, oldest.tail_value);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(predict_result(operation_i, int'(position_i), element_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

/* verif/positional_ordered_list_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the positional ordered list: clock, reset, directed and
// random list operations under several idling patterns, and the verdict.
// Depends on pol_pkg, positional_ordered_list and pol_result_checker.
module positional_ordered_list_tb import pol_pkg::*; ();

  localparam int DEPTH        = 16;
  localparam int HOLD_CYCLES  = 150;
  localparam int BLOCK_ITEMS  = 32;
  localparam int UNUSED_OP_LO = 5;
  localparam int UNUSED_OP_HI = 7;
  localparam int RUN_LIMIT_NS = 10_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  operation_i;
  logic [7:0]  position_i;
  logic [31:0] element_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [4:0]  entry_total_o;
  logic        is_empty_o;
  logic [31:0] head_value_o;
  logic [31:0] tail_value_o;

  int   fail_count;
  int   pending_count;
  int   tx_idle_pct;
  int   rx_stall_pct;
  logic hold_req;

  positional_ordered_list #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(32)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .operation_i,
    .position_i,
    .element_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .read_value_o,
    .entry_total_o,
    .is_empty_o,
    .head_value_o,
    .tail_value_o
  );

  pol_result_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i(in_ready_o),
    .operation_i,
    .position_i,
    .element_i,
    .out_valid_i(out_valid_o),
    .out_ready_i,
    .status_i(status_o),
    .read_value_i(read_value_o),
    .entry_total_i(entry_total_o),
    .is_empty_i(is_empty_o),
    .head_value_i(head_value_o),
    .tail_value_i(tail_value_o),
    .fail_count_o(fail_count),
    .pending_o(pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #10 clk_i = 1'b1;
      #10 clk_i = 1'b0;
    end
  end

  // Receiver: random stalls, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    <= 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(logic [2:0] op, logic [7:0] pos, logic [31:0] word);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    position_i  <= pos;
    element_i   <= word;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic run_directed();
    int i;
    send_item(OP_READ, 8'd0, 32'h0);            // read of an empty list
    send_item(OP_REM_LAST, 8'd0, 32'h0);        // removes from an empty list
    send_item(OP_REM_AT, 8'd5, 32'h0);
    send_item(OP_APPEND, 8'd0, 32'hFFFF_FFFF);
    send_item(OP_REM_AT, 8'd0, 32'h0);          // head with one entry: tail goes
    send_item(OP_APPEND, 8'd0, 32'h0);
    send_item(OP_INSERT, 8'd0, 32'h1234_5678);
    send_item(OP_INSERT, 8'd255, 32'hA5A5_A5A5); // past the end: appended
    send_item(OP_INSERT, 8'd1, 32'h5A5A_5A5A);
    send_item(OP_READ, 8'd3, 32'h0);
    send_item(OP_READ, 8'd4, 32'h0);
    for (i = 0; i < DEPTH - 4; i++) send_item(OP_INSERT, 8'(i % 5), $urandom);
    send_item(OP_APPEND, 8'd0, 32'hDEAD_0001);  // full
    send_item(OP_INSERT, 8'd2, 32'hDEAD_0002);
    send_item(OP_READ, 8'd255, 32'h0);
    send_item(OP_REM_AT, 8'd0, 32'h0);
    send_item(OP_REM_AT, 8'd7, 32'h0);
    send_item(OP_REM_AT, 8'd13, 32'h0);         // last position
    send_item(OP_REM_AT, 8'd200, 32'h0);
    send_item(3'(UNUSED_OP_HI), 8'd255, 32'hFFFF_FFFF);
  endtask

  task automatic send_random_item(bit grow);
    int          pick;
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] word;
    pick = $urandom_range(99);
    if (pick < (grow ? 35 : 12)) op = OP_APPEND;
    else if (pick < (grow ? 60 : 22)) op = OP_INSERT;
    else if (pick < (grow ? 70 : 50)) op = OP_REM_LAST;
    else if (pick < (grow ? 79 : 80)) op = OP_REM_AT;
    else if (pick < 97) op = OP_READ;
    else op = 3'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
    pos = ($urandom_range(99) < 80) ? 8'($urandom_range(0, DEPTH + 1)) : 8'($urandom);
    case ($urandom_range(15))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom;
    endcase
    send_item(op, pos, word);
  endtask

  // Alternating grow and shrink stretches sweep the list between empty and full.
  task automatic run_random(int n_items, int tx_pct, int rx_pct, bit with_hold);
    int i;
    tx_idle_pct   = tx_pct;
    rx_stall_pct <= rx_pct;
    for (i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) hold_req <= 1'b1;
      send_random_item(((i / BLOCK_ITEMS) % 2) == 0);
    end
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    operation_i  = OP_APPEND;
    position_i   = '0;
    element_i    = '0;
    out_ready_i  = 1'b0;
    hold_req     = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();
    run_random(300, 0, 0, 1'b1);
    run_random(300, 48, 0, 1'b0);
    run_random(300, 0, 48, 1'b0);
    run_random(300, 33, 33, 1'b1);
    run_random(300, 0, 0, 1'b0);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
